FILE: design/clct_pkg.sv
// Shared types and constants for the character LCD terminal cursor block.
// Holds the character codes, controller command bytes and the operation
// descriptor that passes from the front end to the back end.
package clct_pkg;

  // Width of the cursor position; holds 0 .. 2*COLUMNS+1 for COLUMNS up to 20.
  localparam int POS_W = 6;

  // Depth of the operation queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Input character codes with a special meaning.
  localparam logic [7:0] CH_BKSP  = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CLEAR = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;

  // Controller bytes.
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_SHIFT_LEFT = 8'h10;
  localparam logic [7:0] CMD_SET_CURSOR = 8'h80;
  localparam logic [7:0] LINE_TWO_BASE  = 8'h40;
  localparam logic [7:0] CMD_LINE_TWO   = CMD_SET_CURSOR | LINE_TWO_BASE;
  localparam logic [7:0] SPACE_CHAR     = 8'h20;

  // Register select values.
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_NEWLINE = 2'd1,
    OP_BKSP    = 2'd2,
    OP_PRINT   = 2'd3
  } op_kind_t;

  // One classified item. scroll means a scroll burst is part of the work;
  // wrap means a move to line two follows a printed character.
  typedef struct packed {
    op_kind_t           kind;
    logic [7:0]         ch;
    logic               scroll;
    logic               wrap;
    logic               far_move;
    logic               wr_en;
    logic [POS_W-1:0]   wr_slot;
  } op_desc_t;

endpackage

FILE: design/clct_front.sv
// Front end of the terminal: accepts characters, tracks the cursor and
// classifies each item into an operation descriptor. Depends on clct_pkg.
module clct_front #(
  parameter int COLUMNS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [7:0]          in_char_code,
  input  logic                q_full,
  output logic                q_push,
  output clct_pkg::op_desc_t  q_desc
);
  import clct_pkg::*;

  localparam logic [POS_W-1:0] POS_HOME = POS_W'(1);
  localparam logic [POS_W-1:0] POS_END1 = POS_W'(COLUMNS);
  localparam logic [POS_W-1:0] POS_L2   = POS_W'(COLUMNS + 1);
  localparam logic [POS_W-1:0] POS_L2B  = POS_W'(COLUMNS + 2);
  localparam logic [POS_W-1:0] POS_END2 = POS_W'(2 * COLUMNS);
  localparam logic [POS_W-1:0] POS_PAST = POS_W'(2 * COLUMNS + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             accept;
  logic             is_op;
  op_desc_t         desc;

  assign accept = in_push && !q_full;

  always_comb begin
    desc         = '0;
    desc.kind    = OP_PRINT;
    desc.ch      = in_char_code;
    is_op        = 1'b1;
    pos_nxt      = pos_r;
    case (in_char_code) inside
      CH_CLEAR: begin
        desc.kind = OP_CLEAR;
        pos_nxt   = POS_HOME;
      end
      CH_LF, CH_CR: begin
        desc.kind   = OP_NEWLINE;
        desc.scroll = (pos_r > POS_END1);
        pos_nxt     = POS_L2;
      end
      CH_BKSP: begin
        desc.kind     = OP_BKSP;
        desc.far_move = (pos_r == POS_L2);
        desc.wr_en    = (pos_r >= POS_L2B) && (pos_r <= POS_PAST);
        desc.wr_slot  = pos_r - POS_L2B;
        pos_nxt       = (pos_r == '0) ? '0 : pos_r - POS_W'(1);
      end
      CH_ESC: begin
        is_op = 1'b0;
      end
      default: begin
        desc.kind    = OP_PRINT;
        desc.wr_en   = (pos_r >= POS_L2) && (pos_r <= POS_END2);
        desc.wr_slot = pos_r - POS_L2;
        desc.wrap    = (pos_r == POS_END1);
        desc.scroll  = (pos_r == POS_END2);
        if (pos_r == POS_END2) begin
          // After the scroll the cursor sits at the start of line two.
          pos_nxt = POS_L2;
        end else if (pos_r < POS_PAST) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HOME;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  assign q_push = accept && is_op;
  assign q_desc = desc;

endmodule

FILE: design/clct_queue.sv
// Short operation queue between the front and back ends of the terminal.
// Depends on clct_pkg for the descriptor type and depth.
module clct_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  clct_pkg::op_desc_t  push_data,
  output logic                full,
  input  logic                pop,
  output clct_pkg::op_desc_t  pop_data,
  output logic                empty
);
  import clct_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(QUEUE_DEPTH);

  op_desc_t         entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_DEPTH);
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_DEPTH)
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

endmodule

FILE: design/clct_back.sv
// Back end of the terminal: runs each operation as a sequence of controller
// transactions, keeps the copy of line two and holds the output register.
// Depends on clct_pkg.
module clct_back #(
  parameter int COLUMNS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  clct_pkg::op_desc_t  q_desc,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [7:0]          out_lcd_byte,
  output logic                out_register_select,
  output logic                out_last_of_burst
);
  import clct_pkg::*;

  localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(COLUMNS - 1);
  localparam logic [7:0] CMD_FAR_MOVE = CMD_SET_CURSOR | 8'(COLUMNS - 1);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_FIRST    = 9'b000000010,
    ST_SPACE    = 9'b000000100,
    ST_MOVE2    = 9'b000001000,
    ST_SC_HOME  = 9'b000010000,
    ST_SC_COPY  = 9'b000100000,
    ST_SC_L2    = 9'b001000000,
    ST_SC_BLANK = 9'b010000000,
    ST_LINE2    = 9'b100000000
  } back_state_t;

  back_state_t      state_r, state_nxt, step_nxt, start_state;
  op_desc_t         cur_r;
  logic [IDX_W-1:0] cnt_r, cnt_nxt, step_cnt;
  logic [7:0]       copy_r [COLUMNS];

  logic             adv;
  logic [7:0]       emit_byte;
  logic             emit_rs;
  logic             emit_last;
  logic             copy_wr;
  logic             copy_clr;
  logic [7:0]       copy_data;
  logic [7:0]       move_byte;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_rs_r;
  logic             out_last_r;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign adv       = (state_r != ST_IDLE) && (!out_valid_r || out_pop);
  assign move_byte = cur_r.far_move ? CMD_FAR_MOVE : CMD_SHIFT_LEFT;

  always_comb begin
    if (q_desc.kind == OP_NEWLINE) begin
      start_state = q_desc.scroll ? ST_SC_HOME : ST_LINE2;
    end else begin
      start_state = ST_FIRST;
    end
  end

  always_comb begin
    step_nxt  = ST_IDLE;
    step_cnt  = cnt_r;
    emit_byte = SPACE_CHAR;
    emit_rs   = RS_DATA;
    emit_last = 1'b0;
    copy_wr   = 1'b0;
    copy_clr  = 1'b0;
    copy_data = SPACE_CHAR;
    case (state_r)
      ST_FIRST: begin
        case (cur_r.kind)
          OP_CLEAR: begin
            emit_byte = CMD_CLEAR;
            emit_rs   = RS_CMD;
            emit_last = 1'b1;
            copy_clr  = 1'b1;
          end
          OP_BKSP: begin
            emit_byte = move_byte;
            emit_rs   = RS_CMD;
            step_nxt  = ST_SPACE;
          end
          OP_PRINT: begin
            emit_byte = cur_r.ch;
            emit_rs   = RS_DATA;
            emit_last = !cur_r.wrap && !cur_r.scroll;
            copy_wr   = cur_r.wr_en;
            copy_data = cur_r.ch;
            if (cur_r.scroll) begin
              step_nxt = ST_SC_HOME;
            end else if (cur_r.wrap) begin
              step_nxt = ST_LINE2;
            end
          end
          default: begin
            emit_last = 1'b1;
          end
        endcase
      end
      ST_SPACE: begin
        step_nxt = ST_MOVE2;
      end
      ST_MOVE2: begin
        emit_byte = move_byte;
        emit_rs   = RS_CMD;
        emit_last = 1'b1;
        copy_wr   = cur_r.wr_en;
      end
      ST_SC_HOME: begin
        emit_byte = CMD_SET_CURSOR;
        emit_rs   = RS_CMD;
        step_cnt  = '0;
        step_nxt  = ST_SC_COPY;
      end
      ST_SC_COPY: begin
        emit_byte = copy_r[cnt_r];
        if (cnt_r == LAST_COL) begin
          step_cnt = '0;
          step_nxt = ST_SC_L2;
        end else begin
          step_cnt = cnt_r + IDX_W'(1);
          step_nxt = ST_SC_COPY;
        end
      end
      ST_SC_L2: begin
        // Every stored character has been sent, so line two starts blank.
        emit_byte = CMD_LINE_TWO;
        emit_rs   = RS_CMD;
        copy_clr  = 1'b1;
        step_nxt  = ST_SC_BLANK;
      end
      ST_SC_BLANK: begin
        if (cnt_r == LAST_COL) begin
          step_cnt = '0;
          step_nxt = ST_LINE2;
        end else begin
          step_cnt = cnt_r + IDX_W'(1);
          step_nxt = ST_SC_BLANK;
        end
      end
      ST_LINE2: begin
        emit_byte = CMD_LINE_TWO;
        emit_rs   = RS_CMD;
        emit_last = 1'b1;
      end
      default: begin
        step_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    if (q_pop) begin
      state_nxt = start_state;
      cnt_nxt   = '0;
    end else if (adv) begin
      state_nxt = step_nxt;
      cnt_nxt   = step_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COLUMNS; i++) begin
        copy_r[i] <= SPACE_CHAR;
      end
    end else if (adv && copy_clr) begin
      for (int i = 0; i < COLUMNS; i++) begin
        copy_r[i] <= SPACE_CHAR;
      end
    end else if (adv && copy_wr) begin
      copy_r[cur_r.wr_slot[IDX_W-1:0]] <= copy_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= emit_byte;
      out_rs_r   <= emit_rs;
      out_last_r <= emit_last;
    end
  end

  assign out_empty           = !out_valid_r;
  assign out_lcd_byte        = out_byte_r;
  assign out_register_select = out_rs_r;
  assign out_last_of_burst   = out_last_r;

  a_last_ends_op: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emit_last |=> state_r == ST_IDLE)
    else $error("sequencer kept running after the last transaction");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SC_COPY || state_r == ST_SC_BLANK) |-> cnt_r <= LAST_COL)
    else $error("scroll column count out of range");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && !out_valid_r |=> !out_valid_r)
    else $error("transaction produced while idle");

  a_scroll_blanks: assert property (@(posedge clk) disable iff (!rst_n)
    adv && state_r == ST_SC_L2 |=> copy_r[0] == SPACE_CHAR)
    else $error("line two copy not blanked by scroll");

endmodule

FILE: design/char_lcd_terminal_cursor_core.sv
// Top level of the character LCD terminal: front end, operation queue and
// back end. Depends on clct_pkg, clct_front, clct_queue and clct_back.
//
//   channel   handshake      payload
//   input     push / full    in_char_code
//   result    empty / pop    out_lcd_byte, out_register_select,
//                            out_last_of_burst
//
// The back end takes an operation from the queue only while idle and then
// sends its transactions one at a time; the longest item, a printed
// character at the end of line two, has the scroll sequencer send
// 2*COLUMNS+4 transactions.
// A stalled result port stops only the back end; the front keeps accepting
// until the queue is full. Escape is accepted and dropped.
// Reset homes the cursor to line one and fills the line two copy with spaces.
module char_lcd_terminal_cursor_core #(
  parameter int COLUMNS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_code,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_lcd_byte,
  output logic       out_register_select,
  output logic       out_last_of_burst
);
  import clct_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  op_desc_t q_wdata;
  op_desc_t q_rdata;

  assign full = q_full;

  clct_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (push),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_desc       (q_wdata)
  );

  clct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  clct_back #(
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_desc              (q_rdata),
    .q_pop               (q_pop),
    .out_empty           (empty),
    .out_pop             (pop),
    .out_lcd_byte        (out_lcd_byte),
    .out_register_select (out_register_select),
    .out_last_of_burst   (out_last_of_burst)
  );

endmodule
